// ----- rtl/dpr_pkg.sv -----
// shared constants, types and codes of the dda polygon rasterizer
// no dependencies; used by dpr_div, dda_polygon_rasterizer and the bench modules
package dpr_pkg;

    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS     = ACC_BITS + 1;
    localparam int LEFT_BITS    = COORD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(ACC_BITS);
    localparam int TDATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int TUSER_BITS   = 2;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    localparam logic ST_PIXEL  = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] mag_x;
        logic [COORD_BITS-1:0] mag_y;
        logic                  neg_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [INC_BITS-1:0] incr_x;
        logic signed [INC_BITS-1:0] incr_y;
    } t_div_rsp;

endpackage

// ----- rtl/dpr_div.sv -----
// bit-serial restoring divider for both axis increments of a line
// depends on dpr_pkg
module dpr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpr_pkg::t_div_req i_req,
    output dpr_pkg::t_div_rsp o_rsp
);
    import dpr_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [COORD_BITS-1:0]   r_den;
    logic                    r_zero;
    logic                    r_neg_x;
    logic                    r_neg_y;
    logic [ACC_BITS-1:0]     r_num_x;
    logic [ACC_BITS-1:0]     r_num_y;
    logic [COORD_BITS-1:0]   r_rem_x;
    logic [COORD_BITS-1:0]   r_rem_y;

    logic [COORD_BITS:0]     n_try_x;
    logic [COORD_BITS:0]     n_try_y;
    logic [COORD_BITS:0]     n_diff_x;
    logic [COORD_BITS:0]     n_diff_y;
    logic                    n_ge_x;
    logic                    n_ge_y;
    logic [INC_BITS-1:0]     n_q_x;
    logic [INC_BITS-1:0]     n_q_y;

    always_comb begin
        n_try_x  = {r_rem_x, r_num_x[ACC_BITS-1]};
        n_try_y  = {r_rem_y, r_num_y[ACC_BITS-1]};
        n_ge_x   = n_try_x >= {1'b0, r_den};
        n_ge_y   = n_try_y >= {1'b0, r_den};
        n_diff_x = n_try_x - {1'b0, r_den};
        n_diff_y = n_try_y - {1'b0, r_den};
        n_q_x    = {1'b0, r_num_x};
        n_q_y    = {1'b0, r_num_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_den   <= i_req.steps;
                r_zero  <= i_req.steps == '0;
                r_neg_x <= i_req.neg_x;
                r_neg_y <= i_req.neg_y;
                r_num_x <= {i_req.mag_x, {FRAC_BITS{1'b0}}};
                r_num_y <= {i_req.mag_y, {FRAC_BITS{1'b0}}};
                r_rem_x <= '0;
                r_rem_y <= '0;
            end else if (r_busy) begin
                r_rem_x <= n_ge_x ? n_diff_x[COORD_BITS-1:0] : n_try_x[COORD_BITS-1:0];
                r_rem_y <= n_ge_y ? n_diff_y[COORD_BITS-1:0] : n_try_y[COORD_BITS-1:0];
                r_num_x <= {r_num_x[ACC_BITS-2:0], n_ge_x};
                r_num_y <= {r_num_y[ACC_BITS-2:0], n_ge_y};
                r_cnt   <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(ACC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done   = r_done;
        o_rsp.incr_x = r_zero ? '0 : (r_neg_x ? -n_q_x : n_q_x);
        o_rsp.incr_y = r_zero ? '0 : (r_neg_y ? -n_q_y : n_q_y);
    end

endmodule

// ----- rtl/dda_polygon_rasterizer.sv -----
// closed-polygon dda rasterizer top level: stream ports, polygon state, step accumulators
// depends on dpr_pkg and dpr_div
//
// Vertex transactions open a polygon or add an edge to it; step transactions return one
// pixel each while an edge is active, steps+1 pixels per edge, where steps is the larger
// axis distance. A step transaction is taken every cycle while the output side keeps up
// and no increments are being computed. A vertex that starts an edge, and the step that
// ends the last edge and starts the closing edge, keep the input closed until the two
// axis increments are computed: they come from a shared bit-serial divider that yields
// one quotient bit per cycle. A vertex sent while an edge still has pixels left is
// answered with a reject status.
module dda_polygon_rasterizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [dpr_pkg::TDATA_BITS-1:0] i_s_axis_tdata,   // vert_x, vert_y
    input  logic                           i_s_axis_tlast,   // closes_polygon
    input  logic [dpr_pkg::TUSER_BITS-1:0] i_s_axis_tuser,   // op, begins_polygon
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [dpr_pkg::TDATA_BITS-1:0] o_m_axis_tdata,   // pixel_x, pixel_y
    output logic                           o_m_axis_tlast,   // line_done
    output logic [dpr_pkg::TUSER_BITS-1:0] o_m_axis_tuser    // polygon_done, status
);
    import dpr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state                r_state;
    logic [COORD_BITS-1:0] r_first_x;
    logic [COORD_BITS-1:0] r_first_y;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [ACC_BITS-1:0]   r_acc_x;
    logic [ACC_BITS-1:0]   r_acc_y;
    logic [INC_BITS-1:0]   r_inc_x;
    logic [INC_BITS-1:0]   r_inc_y;
    logic [LEFT_BITS-1:0]  r_left;
    logic                  r_line_active;
    logic                  r_close_pending;
    logic                  r_polygon_open;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic                  r_out_ldone;
    logic                  r_out_pdone;
    logic                  r_out_status;

    t_div_req              n_req;
    t_div_rsp              n_rsp;
    logic                  n_accept;
    logic                  n_op;
    logic                  n_begins;
    logic                  n_closes;
    logic [COORD_BITS-1:0] n_vx;
    logic [COORD_BITS-1:0] n_vy;
    logic                  n_first_pt;
    logic                  n_start_new;
    logic                  n_start_app;
    logic                  n_start_close;
    logic [COORD_BITS-1:0] n_from_x;
    logic [COORD_BITS-1:0] n_from_y;
    logic [COORD_BITS-1:0] n_to_x;
    logic [COORD_BITS-1:0] n_to_y;
    logic [COORD_BITS:0]   n_dx;
    logic [COORD_BITS:0]   n_dy;
    logic [COORD_BITS:0]   n_abs_x;
    logic [COORD_BITS:0]   n_abs_y;
    logic [COORD_BITS-1:0] n_steps;
    logic [ACC_BITS:0]     n_rnd_x;
    logic [ACC_BITS:0]     n_rnd_y;
    logic [COORD_BITS-1:0] n_pix_x;
    logic [COORD_BITS-1:0] n_pix_y;
    logic                  n_last_pixel;

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_BITS'({r_out_y, r_out_x});
    assign o_m_axis_tlast  = r_out_ldone;
    assign o_m_axis_tuser  = {r_out_status, r_out_pdone};

    always_comb begin
        n_accept   = i_s_axis_tvalid && o_s_axis_tready;
        n_op       = i_s_axis_tuser[0];
        n_begins   = i_s_axis_tuser[1];
        n_closes   = i_s_axis_tlast;
        n_vx       = i_s_axis_tdata[COORD_BITS-1:0];
        n_vy       = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        n_first_pt = n_begins || !r_polygon_open;
        n_last_pixel = r_left == LEFT_BITS'(1);

        n_start_new   = n_accept && (n_op == OP_VERTEX) && !r_line_active
                        && n_first_pt && n_closes;
        n_start_app   = n_accept && (n_op == OP_VERTEX) && !r_line_active && !n_first_pt;
        n_start_close = n_accept && (n_op == OP_STEP) && r_line_active && n_last_pixel
                        && r_close_pending && r_polygon_open;

        n_from_x = n_start_new ? n_vx : r_cur_x;
        n_from_y = n_start_new ? n_vy : r_cur_y;
        n_to_x   = n_start_close ? r_first_x : n_vx;
        n_to_y   = n_start_close ? r_first_y : n_vy;

        n_dx    = {1'b0, n_to_x} - {1'b0, n_from_x};
        n_dy    = {1'b0, n_to_y} - {1'b0, n_from_y};
        n_abs_x = n_dx[COORD_BITS] ? -n_dx : n_dx;
        n_abs_y = n_dy[COORD_BITS] ? -n_dy : n_dy;
        n_steps = (n_abs_x > n_abs_y) ? n_abs_x[COORD_BITS-1:0] : n_abs_y[COORD_BITS-1:0];

        n_req.start = n_start_new || n_start_app || n_start_close;
        n_req.mag_x = n_abs_x[COORD_BITS-1:0];
        n_req.mag_y = n_abs_y[COORD_BITS-1:0];
        n_req.neg_x = n_dx[COORD_BITS];
        n_req.neg_y = n_dy[COORD_BITS];
        n_req.steps = n_steps;

        n_rnd_x = {1'b0, r_acc_x} + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
        n_rnd_y = {1'b0, r_acc_y} + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
        n_pix_x = n_rnd_x[ACC_BITS] ? '1 : n_rnd_x[ACC_BITS-1:FRAC_BITS];
        n_pix_y = n_rnd_y[ACC_BITS] ? '1 : n_rnd_y[ACC_BITS-1:FRAC_BITS];
    end

    dpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_line_active   <= 1'b0;
            r_close_pending <= 1'b0;
            r_polygon_open  <= 1'b0;
            r_left          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (n_req.start) begin
                r_acc_x       <= {n_from_x, {FRAC_BITS{1'b0}}};
                r_acc_y       <= {n_from_y, {FRAC_BITS{1'b0}}};
                r_left        <= {1'b0, n_steps} + 1'b1;
                r_line_active <= 1'b1;
                r_state       <= S_DIV;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept && (n_op == OP_VERTEX)) begin
                        if (r_line_active) begin
                            r_out_valid  <= 1'b1;
                            r_out_x      <= '0;
                            r_out_y      <= '0;
                            r_out_ldone  <= 1'b0;
                            r_out_pdone  <= 1'b0;
                            r_out_status <= ST_REJECT;
                        end else if (n_first_pt) begin
                            r_first_x <= n_vx;
                            r_first_y <= n_vy;
                            r_cur_x   <= n_vx;
                            r_cur_y   <= n_vy;
                            if (n_closes) begin
                                r_polygon_open  <= 1'b0;
                                r_close_pending <= 1'b1;
                            end else begin
                                r_polygon_open  <= 1'b1;
                                r_close_pending <= 1'b0;
                            end
                        end else begin
                            r_cur_x <= n_vx;
                            r_cur_y <= n_vy;
                            if (n_closes) begin
                                r_close_pending <= 1'b1;
                            end
                        end
                    end else if (n_accept && r_line_active) begin
                        r_out_valid  <= 1'b1;
                        r_out_x      <= n_pix_x;
                        r_out_y      <= n_pix_y;
                        r_out_status <= ST_PIXEL;
                        r_out_ldone  <= n_last_pixel;
                        r_out_pdone  <= 1'b0;
                        if (n_last_pixel) begin
                            if (r_close_pending && r_polygon_open) begin
                                r_polygon_open <= 1'b0;
                            end else begin
                                r_line_active <= 1'b0;
                                r_left        <= '0;
                                if (r_close_pending) begin
                                    r_out_pdone     <= 1'b1;
                                    r_close_pending <= 1'b0;
                                end
                            end
                        end else begin
                            r_left  <= r_left - 1'b1;
                            r_acc_x <= r_acc_x + r_inc_x[ACC_BITS-1:0];
                            r_acc_y <= r_acc_y + r_inc_y[ACC_BITS-1:0];
                        end
                    end
                end
                S_DIV: begin
                    if (n_rsp.done) begin
                        r_inc_x <= n_rsp.incr_x;
                        r_inc_y <= n_rsp.incr_y;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_s_axis_tready)
        else $error("input taken while increments are computed");

    a_div_done_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished with no line waiting");

    a_active_line_has_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_left != '0))
        else $error("active line with no pixels left");

    a_reject_payload_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_REJECT))
            |-> (r_out_x == '0 && r_out_y == '0 && !r_out_ldone && !r_out_pdone))
        else $error("reject transaction carries pixel data");

    a_polygon_done_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pdone) |-> r_out_ldone)
        else $error("polygon done without line done");
`endif

endmodule

// ----- bench/dpr_pixel_checker.sv -----
// pixel checker for the dda polygon rasterizer: tracks accepted input transactions,
// predicts the pixel or reject transaction each one causes and compares the output stream
// depends on dpr_pkg
module dpr_pixel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [dpr_pkg::TDATA_BITS-1:0] i_s_axis_tdata,   // vert_x, vert_y
    input  logic                           i_s_axis_tlast,   // closes_polygon
    input  logic [dpr_pkg::TUSER_BITS-1:0] i_s_axis_tuser,   // op, begins_polygon
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [dpr_pkg::TDATA_BITS-1:0] i_m_axis_tdata,   // pixel_x, pixel_y
    input  logic                           i_m_axis_tlast,   // line_done
    input  logic [dpr_pkg::TUSER_BITS-1:0] i_m_axis_tuser,   // polygon_done, status
    output int                             o_errors,
    output int                             o_outstanding,
    output int                             o_pixels,
    output int                             o_rejects,
    output int                             o_polygons
);
    import dpr_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  line_done;
        logic                  polygon_done;
        logic                  status;
    } t_pixel;

    t_pixel expected_pixels[$];
    t_pixel got;
    t_pixel want;

    logic [COORD_BITS-1:0]      start_x, start_y;
    logic [COORD_BITS-1:0]      pen_x, pen_y;
    logic signed [INC_BITS-1:0] acc_x, acc_y;
    logic signed [INC_BITS-1:0] slope_x, slope_y;
    logic [LEFT_BITS-1:0]       pixels_to_go;
    logic                       drawing;
    logic                       closing;
    logic                       poly_open;

    function automatic logic signed [INC_BITS-1:0] axis_slope(
        logic signed [COORD_BITS:0] d, logic [COORD_BITS-1:0] n);
        logic [COORD_BITS-1:0] mag;
        logic [ACC_BITS-1:0]   quo;
        if (n == 0)
            return '0;
        mag = COORD_BITS'((d < 0) ? -d : d);
        quo = {mag, {FRAC_BITS{1'b0}}} / n;
        return (d < 0) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    endfunction

    function automatic void begin_edge(logic [COORD_BITS-1:0] fx, logic [COORD_BITS-1:0] fy,
                                       logic [COORD_BITS-1:0] tx, logic [COORD_BITS-1:0] ty);
        logic signed [COORD_BITS:0] dx, dy;
        logic [COORD_BITS-1:0]      ax, ay, n;
        dx = $signed({1'b0, tx}) - $signed({1'b0, fx});
        dy = $signed({1'b0, ty}) - $signed({1'b0, fy});
        ax = COORD_BITS'((dx < 0) ? -dx : dx);
        ay = COORD_BITS'((dy < 0) ? -dy : dy);
        n  = (ax > ay) ? ax : ay;
        acc_x        = $signed({1'b0, fx, {FRAC_BITS{1'b0}}});
        acc_y        = $signed({1'b0, fy, {FRAC_BITS{1'b0}}});
        slope_x      = axis_slope(dx, n);
        slope_y      = axis_slope(dy, n);
        pixels_to_go = {1'b0, n} + 1'b1;
        drawing      = 1'b1;
    endfunction

    function automatic logic [COORD_BITS-1:0] to_pixel(logic signed [INC_BITS-1:0] acc);
        logic [INC_BITS:0] sum;
        if (acc < 0)
            return '0;
        sum = ({1'b0, acc} + (INC_BITS + 1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (sum > COORD_MAX) ? '1 : sum[COORD_BITS-1:0];
    endfunction

    function automatic void rasterize_item(logic op, logic [COORD_BITS-1:0] vx,
                                           logic [COORD_BITS-1:0] vy, logic begins,
                                           logic closes);
        t_pixel p;
        p = '0;
        if (op == OP_VERTEX) begin
            if (drawing) begin
                p.status = ST_REJECT;
                expected_pixels.push_back(p);
            end else if (begins || !poly_open) begin
                start_x = vx;
                start_y = vy;
                pen_x   = vx;
                pen_y   = vy;
                if (closes) begin
                    poly_open = 1'b0;
                    closing   = 1'b1;
                    begin_edge(vx, vy, vx, vy);
                end else begin
                    poly_open = 1'b1;
                    closing   = 1'b0;
                end
            end else begin
                begin_edge(pen_x, pen_y, vx, vy);
                pen_x = vx;
                pen_y = vy;
                if (closes)
                    closing = 1'b1;
            end
            return;
        end
        if (!drawing)
            return;
        p.x      = to_pixel(acc_x);
        p.y      = to_pixel(acc_y);
        p.status = ST_PIXEL;
        if (pixels_to_go > 0)
            pixels_to_go = pixels_to_go - 1'b1;
        if (pixels_to_go == 0) begin
            p.line_done = 1'b1;
            drawing     = 1'b0;
            if (closing) begin
                if (poly_open) begin
                    poly_open = 1'b0;
                    begin_edge(pen_x, pen_y, start_x, start_y);
                end else begin
                    p.polygon_done = 1'b1;
                    closing        = 1'b0;
                end
            end
        end else begin
            acc_x = acc_x + slope_x;
            acc_y = acc_y + slope_y;
        end
        expected_pixels.push_back(p);
    endfunction

    initial begin
        o_errors      = 0;
        o_pixels      = 0;
        o_rejects     = 0;
        o_polygons    = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_x      = '0;
            start_y      = '0;
            pen_x        = '0;
            pen_y        = '0;
            acc_x        = '0;
            acc_y        = '0;
            slope_x      = '0;
            slope_y      = '0;
            pixels_to_go = '0;
            drawing      = 1'b0;
            closing      = 1'b0;
            poly_open    = 1'b0;
            expected_pixels.delete();
        end else begin
            // output side first: a result never belongs to the transaction taken this edge
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.x            = i_m_axis_tdata[COORD_BITS-1:0];
                got.y            = i_m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                got.line_done    = i_m_axis_tlast;
                got.polygon_done = i_m_axis_tuser[0];
                got.status       = i_m_axis_tuser[1];
                if (expected_pixels.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected transaction x=%0d y=%0d line_done=%0d ",
                             $time, got.x, got.y, got.line_done,
                             "polygon_done=%0d status=%0d", got.polygon_done, got.status);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        $display("%0t: mismatch expected x=%0d y=%0d line_done=%0d ",
                                 $time, want.x, want.y, want.line_done,
                                 "polygon_done=%0d status=%0d", want.polygon_done,
                                 want.status);
                        $display("%0t:          actual   x=%0d y=%0d line_done=%0d ",
                                 $time, got.x, got.y, got.line_done,
                                 "polygon_done=%0d status=%0d", got.polygon_done,
                                 got.status);
                    end
                    if (want.status == ST_REJECT)
                        o_rejects++;
                    else
                        o_pixels++;
                    if (want.polygon_done)
                        o_polygons++;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                rasterize_item(i_s_axis_tuser[0], i_s_axis_tdata[COORD_BITS-1:0],
                               i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS],
                               i_s_axis_tuser[1], i_s_axis_tlast);
        end
        o_outstanding <= expected_pixels.size();
    end

endmodule

// ----- bench/dda_polygon_rasterizer_test.sv -----
// testbench top for the dda polygon rasterizer: clock, reset, polygon stimulus and verdict
// depends on dpr_pkg, dda_polygon_rasterizer and dpr_pixel_checker
module dda_polygon_rasterizer_test;
    import dpr_pkg::*;

    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int LIMIT       = 600000;
    localparam int HOLDOFF     = 400;
    localparam int SETTLE      = COORD_BITS + FRAC_BITS + 10;
    localparam int PHASE_ITEMS = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata;   // vert_x, vert_y
    logic                  s_tlast;   // closes_polygon
    logic [TUSER_BITS-1:0] s_tuser;   // op, begins_polygon
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_BITS-1:0] m_tdata;   // pixel_x, pixel_y
    logic                  m_tlast;   // line_done
    logic [TUSER_BITS-1:0] m_tuser;   // polygon_done, status

    int errors, outstanding, pixels, rejects, polygons;
    int cycles        = 0;
    int items_sent    = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int reject_pct    = 0;
    int holdoff_asked = 0;
    int holdoff_done  = 0;
    int anchor_x, anchor_y, pen_x, pen_y;
    bit may_be_open;

    int idle_by_phase[4]  = '{0, 49, 0, 15};
    int stall_by_phase[4] = '{0, 0, 49, 15};

    dda_polygon_rasterizer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    dpr_pixel_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_m_axis_tuser  (m_tuser),
        .o_errors        (errors),
        .o_outstanding   (outstanding),
        .o_pixels        (pixels),
        .o_rejects       (rejects),
        .o_polygons      (polygons)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_done != holdoff_asked) begin
                holdoff_done = holdoff_asked;
                m_tready <= 1'b0;
                repeat (HOLDOFF) @(posedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y, input logic begins,
                             input logic closes);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_BITS - 2 * COORD_BITS){1'b0}}, y, x};
        s_tlast  <= closes;
        s_tuser  <= {begins, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic step_once();
        send_item(OP_STEP, COORD_BITS'($urandom_range(COORD_MAX)),
                  COORD_BITS'($urandom_range(COORD_MAX)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic run_steps(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < reject_pct)
                send_item(OP_VERTEX, COORD_BITS'($urandom_range(COORD_MAX)),
                          COORD_BITS'($urandom_range(COORD_MAX)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            step_once();
        end
    endtask

    function automatic int edge_pixels(int x0, int y0, int x1, int y1);
        int ax, ay;
        ax = (x1 > x0) ? x1 - x0 : x0 - x1;
        ay = (y1 > y0) ? y1 - y0 : y0 - y1;
        return ((ax > ay) ? ax : ay) + 1;
    endfunction

    function automatic int wander(int v, int lim);
        int r;
        r = v + int'($urandom_range(2 * lim)) - lim;
        if (r < 0)
            r = 0;
        if (r > COORD_MAX)
            r = COORD_MAX;
        return r;
    endfunction

    task automatic open_polygon(input int x, input int y, input logic begins,
                                input logic closes);
        send_item(OP_VERTEX, COORD_BITS'(x), COORD_BITS'(y), begins, closes);
        anchor_x = x;
        anchor_y = y;
        pen_x    = x;
        pen_y    = y;
        if (closes)
            run_steps(1);
    endtask

    task automatic draw_edge(input int x, input int y, input logic closes);
        int n;
        send_item(OP_VERTEX, COORD_BITS'(x), COORD_BITS'(y), $urandom_range(1) && 1'b0,
                  closes);
        n = edge_pixels(pen_x, pen_y, x, y);
        if (closes)
            n += edge_pixels(x, y, anchor_x, anchor_y);
        pen_x = x;
        pen_y = y;
        run_steps(n);
    endtask

    task automatic random_polygon();
        int   n_edges, lim;
        logic begins, closes;
        bit   abandon;
        begins  = (!may_be_open && $urandom_range(3) == 0) ? 1'b0 : 1'b1;
        open_polygon($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), begins, 1'b0);
        n_edges = $urandom_range(5, 1);
        abandon = ($urandom_range(6) == 0);
        for (int e = 0; e < n_edges; e++) begin
            lim    = ($urandom_range(9) == 0) ? 40 : 8;
            closes = (e == n_edges - 1) && !abandon;
            draw_edge(wander(pen_x, lim), wander(pen_y, lim), closes);
        end
        may_be_open = abandon;
    endtask

    task automatic one_point_polygon();
        logic begins;
        begins = may_be_open ? 1'b1 : logic'($urandom_range(1));
        open_polygon($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), begins, 1'b1);
        may_be_open = 1'b0;
    endtask

    // unordered transactions in a small corner, then enough steps to finish any edge
    task automatic noise_burst();
        repeat ($urandom_range(6, 1))
            send_item(1'($urandom_range(1)), COORD_BITS'($urandom_range(15)),
                      COORD_BITS'($urandom_range(15)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (40) step_once();
        may_be_open = 1'b1;
    endtask

    task automatic pause_until_empty();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        int goal, pick;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        step_once();
        open_polygon(0, 0, 1'b0, 1'b0);
        reject_pct = 100;
        draw_edge(3, 1, 1'b0);
        reject_pct = 0;
        draw_edge(0, 2, 1'b1);
        step_once();
        open_polygon(COORD_MAX, COORD_MAX, 1'b1, 1'b1);
        step_once();
        open_polygon(COORD_MAX, 0, 1'b1, 1'b0);
        draw_edge(COORD_MAX, 0, 1'b1);
        open_polygon(512, 512, 1'b1, 1'b0);
        open_polygon(1020, 1021, 1'b1, 1'b0);
        draw_edge(COORD_MAX, COORD_MAX, 1'b1);
        pause_until_empty();

        // long edge while the output side holds off
        holdoff_asked++;
        open_polygon(100, 300, 1'b1, 1'b0);
        draw_edge(400, 310, 1'b1);
        pause_until_empty();
        may_be_open = 1'b0;

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct   = idle_by_phase[phase];
            stall_pct  = stall_by_phase[phase];
            reject_pct = 3;
            goal       = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 75)
                    random_polygon();
                else if (pick < 88)
                    one_point_polygon();
                else
                    noise_burst();
            end
            pause_until_empty();
        end

        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d input transactions: directed corners, a long output hold-off",
                 items_sent);
        $display("and four pacing phases; %0d pixels, %0d rejected vertices, %0d polygons",
                 pixels, rejects, polygons);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dpr_pkg.sv
rtl/dpr_div.sv
rtl/dda_polygon_rasterizer.sv
bench/dpr_pixel_checker.sv
bench/dda_polygon_rasterizer_test.sv
